>>> rtl/pra_pkg.sv
// ----------------------------------------------------------------------------
// pra_pkg
// Shared types, codes and saturation helpers for the rate PID controller.
// ----------------------------------------------------------------------------
package pra_pkg;

	// shift applied after a multiply
	localparam logic [1:0] SH_0  = 2'd0;
	localparam logic [1:0] SH_16 = 2'd1;
	localparam logic [1:0] SH_24 = 2'd2;

	// configuration register indexes
	localparam logic [2:0] REG_PROP_GAIN    = 3'd0;
	localparam logic [2:0] REG_INTEG_GAIN   = 3'd1;
	localparam logic [2:0] REG_DERIV_GAIN   = 3'd2;
	localparam logic [2:0] REG_FEEDFWD_GAIN = 3'd3;
	localparam logic [2:0] REG_INTEG_LIMIT  = 3'd4;
	localparam logic [2:0] REG_FILTER_TAU   = 3'd5;
	localparam logic [2:0] REG_OUTPUT_LIMIT = 3'd6;

	// 0.3 in Q0.16
	localparam logic [31:0] AW_GAIN = 32'd19661;

	localparam logic signed [63:0] I32_MAX64 = 64'sd2147483647;
	localparam logic signed [63:0] I32_MIN64 = -64'sd2147483648;
	localparam logic signed [64:0] I40_MAX65 = 65'sd549755813887;
	localparam logic signed [64:0] I40_MIN65 = -65'sd549755813888;

	typedef struct packed {
		logic [31:0]        a_mag;
		logic               a_neg;
		logic signed [63:0] b;
		logic [1:0]         shift;
	} mul_req_t;

	typedef struct packed {
		logic [32:0] rem0;
		logic [31:0] low0;
		logic [32:0] den;
		logic [5:0]  nbits;
	} div_req_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > I32_MAX64) begin
			r = 32'sh7fffffff;
		end else if (v < I32_MIN64) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [39:0] sat40(input logic signed [64:0] v);
		logic signed [39:0] r;
		if (v > I40_MAX65) begin
			r = 40'sh7fffffffff;
		end else if (v < I40_MIN65) begin
			r = 40'sh8000000000;
		end else begin
			r = v[39:0];
		end
		return r;
	endfunction

endpackage

>>> rtl/pra_mul.sv
// ----------------------------------------------------------------------------
// pra_mul
// Shared 32x32 multiplier: signed (a*b)>>s toward zero, magnitude capped at
// 2^62, b up to 64 bits taken as two partial products.
// ----------------------------------------------------------------------------
module pra_mul (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  pra_pkg::mul_req_t  req,
	output logic               done,
	output logic signed [63:0] result
);
	import pra_pkg::*;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_HI   = 2'd1;
	localparam logic [1:0] PH_LO   = 2'd2;
	localparam logic [1:0] PH_CMB  = 2'd3;
	localparam logic [65:0] MAG_CAP = 66'h1 << 62;

	logic [1:0]  phase_q;
	logic [31:0] a_q;
	logic [63:0] b_q;
	logic        neg_q;
	logic [1:0]  sh_q;
	logic [63:0] hi_q, lo_q;
	logic        done_q;
	logic signed [63:0] res_q;

	logic [63:0] b_mag;
	logic [63:0] prod;
	logic        hi_ovf;
	logic [65:0] hi_sh;
	logic [63:0] lo_sh;
	logic [65:0] r_sum;
	logic [63:0] mag;

	assign b_mag = req.b[63] ? 64'(-req.b) : 64'(req.b);
	assign prod  = 64'(a_q) * 64'((phase_q == PH_HI) ? b_q[63:32] : b_q[31:0]);

	always_comb begin
		case (sh_q)
			SH_16: begin
				hi_ovf = |hi_q[63:46];
				hi_sh  = {hi_q[49:0], 16'b0};
				lo_sh  = {16'b0, lo_q[63:16]};
			end
			SH_24: begin
				hi_ovf = |hi_q[63:54];
				hi_sh  = {hi_q[57:0], 8'b0};
				lo_sh  = {24'b0, lo_q[63:24]};
			end
			default: begin
				hi_ovf = |hi_q[63:30];
				hi_sh  = {hi_q[33:0], 32'b0};
				lo_sh  = lo_q;
			end
		endcase
		r_sum = hi_sh + {2'b0, lo_sh};
		mag   = (hi_ovf || (r_sum > MAG_CAP)) ? MAG_CAP[63:0] : r_sum[63:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (phase_q == PH_CMB);
			case (phase_q)
				PH_IDLE: if (start) phase_q <= PH_HI;
				PH_HI:   phase_q <= PH_LO;
				PH_LO:   phase_q <= PH_CMB;
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && phase_q == PH_IDLE) begin
			a_q   <= req.a_mag;
			b_q   <= b_mag;
			neg_q <= req.a_neg ^ req.b[63];
			sh_q  <= req.shift;
		end
		if (phase_q == PH_HI) hi_q <= prod;
		if (phase_q == PH_LO) lo_q <= prod;
		if (phase_q == PH_CMB) res_q <= neg_q ? -$signed(mag) : $signed(mag);
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

>>> rtl/pra_div.sv
// ----------------------------------------------------------------------------
// pra_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pra_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  pra_pkg::div_req_t req,
	output logic              done,
	output logic [31:0]       quo
);
	import pra_pkg::*;

	logic [5:0]  cnt_q;
	logic [32:0] rem_q;
	logic [31:0] low_q;
	logic [32:0] den_q;
	logic        done_q;

	logic [33:0] rem2;
	logic        ge;
	logic [33:0] diff;

	assign rem2 = {rem_q, low_q[31]};
	assign ge   = rem2 >= {1'b0, den_q};
	assign diff = rem2 - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == 6'd1);
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - 6'd1;
			end else if (start) begin
				cnt_q <= req.nbits;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_q != '0) begin
			rem_q <= ge ? diff[32:0] : rem2[32:0];
			low_q <= {low_q[30:0], ge};
		end else if (start) begin
			rem_q <= req.rem0;
			low_q <= req.low0;
			den_q <= req.den;
		end
	end

	assign done = done_q;
	assign quo  = low_q;

endmodule

>>> rtl/pid_rate_axis_controller.sv
// ----------------------------------------------------------------------------
// pid_rate_axis_controller
// Single-axis rate PID, derivative on measurement, back-calculation anti-windup.
// ----------------------------------------------------------------------------
// One item is worked at a time by a sequencer that drives a shared 32x32
// multiplier and a one-bit-per-cycle divider. A control step takes longest
// with a sample division and anti-windup; the quotient of the measurement
// slope (32 bits) and the filter coefficient (25 bits) dominate. A clear item
// or a zero time step goes straight to the done state. in_ready is high only
// while the sequencer is idle; one finished result may wait in the output
// register. Configuration writes are always taken and must come while idle.
module pid_rate_axis_controller (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               cmd,
	input  logic signed [31:0] target,
	input  logic signed [31:0] sample,
	input  logic [23:0]        step_time,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] drive,
	output logic               limited,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import pra_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_INT1  = 4'd1;
	localparam logic [3:0] S_INT2  = 4'd2;
	localparam logic [3:0] S_P     = 4'd3;
	localparam logic [3:0] S_FF    = 4'd4;
	localparam logic [3:0] S_RAW   = 4'd5;
	localparam logic [3:0] S_ALPHA = 4'd6;
	localparam logic [3:0] S_F1    = 4'd7;
	localparam logic [3:0] S_F2    = 4'd8;
	localparam logic [3:0] S_F3    = 4'd9;
	localparam logic [3:0] S_D     = 4'd10;
	localparam logic [3:0] S_OUT   = 4'd11;
	localparam logic [3:0] S_AW1   = 4'd12;
	localparam logic [3:0] S_AW2   = 4'd13;
	localparam logic [3:0] S_DONE  = 4'd14;

	// configuration
	logic [31:0]        prop_q, igain_q, dgain_q, tau_q;
	logic signed [31:0] ffg_q;
	logic [30:0]        ilim_q, olim_q;

	// controller state
	logic signed [39:0] integ_q;
	logic signed [31:0] dfilt_q, prev_q;
	logic               primed_q;

	// per-item work registers
	logic [3:0]         state_q;
	logic               wait_q;
	logic signed [31:0] target_q, sample_q, err_q, raw_q;
	logic [23:0]        dt_q;
	logic [24:0]        alpha_q;
	logic signed [63:0] acc_q;
	logic signed [34:0] sum_q, excess_q;
	logic signed [31:0] drv_q;
	logic               lim_q;
	logic               out_valid_q;
	logic signed [31:0] drive_q;
	logic               limited_q;

	// shared units
	mul_req_t           mreq;
	div_req_t           dreq;
	logic               mstart, mdone, dstart, ddone;
	logic signed [63:0] mres;
	logic [31:0]        dquo;

	logic signed [32:0] diff;
	logic [32:0]        dmag;
	logic               slope_ovf;
	logic               mul_state;
	logic signed [32:0] err_wide;
	logic signed [63:0] integ_sum, ilim64;
	logic signed [63:0] fmag, fval;
	logic signed [34:0] olim35;
	logic signed [34:0] drv35;

	pra_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mstart),
		.req    (mreq),
		.done   (mdone),
		.result (mres)
	);

	pra_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dstart),
		.req    (dreq),
		.done   (ddone),
		.quo    (dquo)
	);

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign drive     = drive_q;
	assign limited   = limited_q;

	assign diff      = {sample_q[31], sample_q} - {prev_q[31], prev_q};
	assign dmag      = diff[32] ? 33'(-diff) : 33'(diff);
	assign slope_ovf = dmag >= {1'b0, dt_q, 8'b0};
	assign err_wide  = {target[31], target} - {sample[31], sample};
	assign integ_sum = 64'(integ_q) + mres;
	assign ilim64    = $signed({25'b0, ilim_q, 8'b0});
	assign fmag      = acc_q[63] ? -acc_q : acc_q;
	assign fval      = acc_q[63] ? -(fmag >>> 24) : (fmag >>> 24);
	assign olim35    = $signed({4'b0, olim_q});

	always_comb begin
		case (state_q)
			S_INT1, S_INT2, S_P, S_FF, S_F1, S_F2, S_D, S_AW1, S_AW2: mul_state = 1'b1;
			default: mul_state = 1'b0;
		endcase
	end

	assign mstart = mul_state && !wait_q;
	assign dstart = !wait_q && ((state_q == S_ALPHA) ||
		(state_q == S_RAW && primed_q && !slope_ovf));

	always_comb begin
		mreq = '0;
		case (state_q)
			S_INT1: begin
				mreq.a_mag = {8'b0, dt_q};
				mreq.b     = 64'(err_q);
				mreq.shift = SH_16;
			end
			S_INT2: begin
				mreq.a_mag = igain_q;
				mreq.b     = 64'(integ_q);
				mreq.shift = SH_24;
			end
			S_P: begin
				mreq.a_mag = prop_q;
				mreq.b     = 64'(err_q);
				mreq.shift = SH_16;
			end
			S_FF: begin
				mreq.a_mag = ffg_q[31] ? 32'(-ffg_q) : 32'(ffg_q);
				mreq.a_neg = ffg_q[31];
				mreq.b     = 64'(target_q);
				mreq.shift = SH_16;
			end
			S_F1: begin
				mreq.a_mag = {7'b0, alpha_q};
				mreq.b     = 64'(raw_q);
				mreq.shift = SH_0;
			end
			S_F2: begin
				mreq.a_mag = {7'b0, 25'h1000000 - alpha_q};
				mreq.b     = 64'(dfilt_q);
				mreq.shift = SH_0;
			end
			S_D: begin
				mreq.a_mag = dgain_q;
				mreq.b     = 64'(dfilt_q);
				mreq.shift = SH_16;
			end
			S_AW1: begin
				mreq.a_mag = {8'b0, dt_q};
				mreq.b     = 64'(excess_q);
				mreq.shift = SH_16;
			end
			S_AW2: begin
				mreq.a_mag = AW_GAIN;
				mreq.b     = acc_q;
				mreq.shift = SH_16;
			end
			default: mreq = '0;
		endcase
	end

	always_comb begin
		if (state_q == S_ALPHA) begin
			dreq.rem0  = {10'b0, dt_q[23:1]};
			dreq.low0  = {dt_q[0], 31'b0};
			dreq.den   = {1'b0, tau_q} + {9'b0, dt_q};
			dreq.nbits = 6'd25;
		end else begin
			dreq.rem0  = {8'b0, dmag[32:8]};
			dreq.low0  = {dmag[7:0], 24'b0};
			dreq.den   = {9'b0, dt_q};
			dreq.nbits = 6'd32;
		end
	end

	always_comb begin
		if (sum_q > olim35) begin
			drv35 = olim35;
		end else if (sum_q < -olim35) begin
			drv35 = -olim35;
		end else begin
			drv35 = sum_q;
		end
	end

	// configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_q  <= '0;
			igain_q <= '0;
			dgain_q <= '0;
			ffg_q   <= '0;
			ilim_q  <= '0;
			tau_q   <= '0;
			olim_q  <= 31'h7fffffff;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PROP_GAIN:    prop_q  <= cfg_data;
				REG_INTEG_GAIN:   igain_q <= cfg_data;
				REG_DERIV_GAIN:   dgain_q <= cfg_data;
				REG_FEEDFWD_GAIN: ffg_q   <= $signed(cfg_data);
				REG_INTEG_LIMIT:  ilim_q  <= cfg_data[30:0];
				REG_FILTER_TAU:   tau_q   <= cfg_data;
				REG_OUTPUT_LIMIT: olim_q  <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wait_q      <= 1'b0;
			integ_q     <= '0;
			dfilt_q     <= '0;
			prev_q      <= '0;
			primed_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_DONE) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						target_q <= target;
						sample_q <= sample;
						dt_q     <= step_time;
						err_q    <= sat32(64'(err_wide));
						drv_q    <= '0;
						lim_q    <= 1'b0;
						wait_q   <= 1'b0;
						if (cmd) begin
							integ_q  <= '0;
							dfilt_q  <= '0;
							prev_q   <= '0;
							primed_q <= 1'b0;
							state_q  <= S_DONE;
						end else if (step_time == '0) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_INT1;
						end
					end
				end
				S_RAW: begin
					if (!primed_q || slope_ovf) begin
						raw_q    <= !primed_q ? 32'sd0 :
							(diff[32] ? 32'sh80000000 : 32'sh7fffffff);
						prev_q   <= sample_q;
						primed_q <= 1'b1;
						state_q  <= S_ALPHA;
					end else if (!wait_q) begin
						wait_q <= 1'b1;
					end else if (ddone) begin
						if (!diff[32]) begin
							raw_q <= dquo[31] ? 32'sh7fffffff : $signed(dquo);
						end else begin
							raw_q <= (dquo > 32'h80000000) ? 32'sh80000000 : $signed(-dquo);
						end
						prev_q   <= sample_q;
						primed_q <= 1'b1;
						wait_q   <= 1'b0;
						state_q  <= S_ALPHA;
					end
				end
				S_ALPHA: begin
					if (!wait_q) begin
						wait_q <= 1'b1;
					end else if (ddone) begin
						alpha_q <= dquo[24:0];
						wait_q  <= 1'b0;
						state_q <= S_F1;
					end
				end
				S_F3: begin
					dfilt_q <= sat32(fval);
					state_q <= S_D;
				end
				S_OUT: begin
					drv_q    <= drv35[31:0];
					lim_q    <= (sum_q != drv35);
					excess_q <= sum_q - drv35;
					state_q  <= (sum_q != drv35) ? S_AW1 : S_DONE;
				end
				S_DONE: begin
					// hold until the output register is free
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						drive_q     <= drv_q;
						limited_q   <= lim_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					if (!wait_q) begin
						wait_q <= 1'b1;
					end else if (mdone) begin
						wait_q <= 1'b0;
						case (state_q)
							S_INT1: begin
								if (integ_sum > ilim64) begin
									integ_q <= ilim64[39:0];
								end else if (integ_sum < -ilim64) begin
									integ_q <= 40'(-ilim64);
								end else begin
									integ_q <= integ_sum[39:0];
								end
								state_q <= S_INT2;
							end
							S_INT2: begin
								sum_q   <= 35'(sat32(mres));
								state_q <= S_P;
							end
							S_P: begin
								sum_q   <= sum_q + 35'(sat32(mres));
								state_q <= S_FF;
							end
							S_FF: begin
								sum_q   <= sum_q + 35'(sat32(mres));
								state_q <= S_RAW;
							end
							S_F1: begin
								acc_q   <= mres;
								state_q <= S_F2;
							end
							S_F2: begin
								acc_q   <= acc_q + mres;
								state_q <= S_F3;
							end
							S_D: begin
								sum_q   <= sum_q + 35'(sat32(-mres));
								state_q <= S_OUT;
							end
							S_AW1: begin
								acc_q   <= mres;
								state_q <= S_AW2;
							end
							S_AW2: begin
								integ_q <= sat40(65'(integ_q) - 65'(mres));
								state_q <= S_DONE;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
			endcase
		end
	end

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second item taken while busy");

	a_drive_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($signed({drive[31], drive}) <= $signed({2'b0, olim_q}) &&
		$signed({drive[31], drive}) >= -$signed({2'b0, olim_q})))
		else $error("drive outside output limit");

	a_units_apart: assert property (@(posedge clk) disable iff (!arst_n)
		!(mdone && ddone))
		else $error("multiplier and divider finished together");

	a_start_once: assert property (@(posedge clk) disable iff (!arst_n)
		(mstart || dstart) |=> !(mstart || dstart))
		else $error("unit started twice in a row");

endmodule
